[hw/rtl/assert_macros.svh]
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define VPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define VPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/vps_pkg.sv]
package vps_pkg;

    typedef enum logic [2:0] {
        REG_DELTA_TIME    = 3'd0,
        REG_DRAG          = 3'd1,
        REG_ACCEL_X       = 3'd2,
        REG_ACCEL_Y       = 3'd3,
        REG_ELASTICITY    = 3'd4,
        REG_CURSOR_SIZE   = 3'd5,
        REG_WINDOW_WIDTH  = 3'd6,
        REG_WINDOW_HEIGHT = 3'd7
    } reg_index_t;

    localparam int CFG_DATA_W = 24;

    localparam logic [15:0]        RST_DELTA_TIME    = 16'd1092;
    localparam logic [15:0]        RST_DRAG          = 16'd655;
    localparam logic signed [23:0] RST_ACCEL_X       = 24'sd0;
    localparam logic signed [23:0] RST_ACCEL_Y       = 24'sd256000;
    localparam logic [18:0]        RST_ELASTICITY    = 19'd640;
    localparam logic [17:0]        RST_CURSOR_SIZE   = 18'd1280;
    localparam logic [11:0]        RST_WINDOW_WIDTH  = 12'd800;
    localparam logic [11:0]        RST_WINDOW_HEIGHT = 12'd600;

    typedef struct packed {
        logic [15:0]        delta_time;
        logic [15:0]        drag;
        logic signed [23:0] accel_x;
        logic signed [23:0] accel_y;
        logic [18:0]        elasticity;
        logic [17:0]        cursor_size;
        logic [11:0]        window_width;
        logic [11:0]        window_height;
    } cfg_t;

    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] prev_x;
        logic signed [19:0] prev_y;
        logic signed [19:0] init_x;
        logic signed [19:0] init_y;
        logic               pinned;
        logic signed [19:0] mouse_x;
        logic signed [19:0] mouse_y;
        logic signed [19:0] mouse_prev_x;
        logic signed [19:0] mouse_prev_y;
        logic [1:0]         buttons;
    } in_item_t;

    // classified particle handed from front to back; prev already drag-adjusted
    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] prev_x;
        logic signed [19:0] prev_y;
        logic signed [19:0] init_x;
        logic signed [19:0] init_y;
        logic               pinned;
        logic               selected;
        logic               break_links;
    } mid_item_t;

    typedef struct packed {
        logic signed [19:0] new_pos_x;
        logic signed [19:0] new_pos_y;
        logic signed [19:0] new_prev_x;
        logic signed [19:0] new_prev_y;
        logic               selected;
        logic               break_links;
    } out_item_t;

endpackage

[hw/rtl/vps_queue.sv]
module vps_queue #(
    parameter int  DEPTH = 4,
    parameter type T     = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  T     wr_item,
    output logic rd_valid,
    input  logic rd_ready,
    output T     rd_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    T              mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_ready && rd_valid;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[hw/rtl/vps_front.sv]
module vps_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vps_pkg::in_item_t   in_item,
    input  vps_pkg::cfg_t       cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output vps_pkg::mid_item_t  out_item
);

    import vps_pkg::*;

    logic               s0_valid_reg, s1_valid_reg, s2_valid_reg;
    logic               en0, en1, en2;
    in_item_t           s0_item_reg, s1_item_reg;
    logic signed [20:0] elast_s, dmx, dmy;
    logic signed [20:0] dx_next, dy_next, ddx_next, ddy_next;
    logic signed [20:0] dx_reg, dy_reg, ddx_reg, ddy_reg;
    logic signed [41:0] sqx_reg, sqy_reg;
    logic [35:0]        csq_reg;
    logic signed [19:0] dragx_reg, dragy_reg;
    logic signed [42:0] dist_sq;
    logic               sel;
    mid_item_t          s2_next, s2_item_reg;

    function automatic logic signed [20:0] clamp_elast(
        input logic signed [20:0] d,
        input logic signed [20:0] e
    );
        logic signed [20:0] r;
        if (d > e)
        begin
            r = e;
        end
        else if (d < -e)
        begin
            r = -e;
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

    function automatic logic signed [19:0] sat_pos(input logic signed [21:0] v);
        logic signed [19:0] r;
        if (v[21] && !(&v[20:19]))
        begin
            r = {1'b1, 19'd0};
        end
        else if (!v[21] && (|v[20:19]))
        begin
            r = {1'b0, {19{1'b1}}};
        end
        else
        begin
            r = v[19:0];
        end
        return r;
    endfunction

    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign en0      = !s0_valid_reg || en1;
    assign in_ready = en0;

    assign elast_s  = $signed({2'b00, cfg.elasticity});
    assign dx_next  = 21'(in_item.pos_x) - 21'(in_item.mouse_x);
    assign dy_next  = 21'(in_item.pos_y) - 21'(in_item.mouse_y);
    assign dmx      = 21'(in_item.mouse_x) - 21'(in_item.mouse_prev_x);
    assign dmy      = 21'(in_item.mouse_y) - 21'(in_item.mouse_prev_y);
    assign ddx_next = clamp_elast(dmx, elast_s);
    assign ddy_next = clamp_elast(dmy, elast_s);

    assign dist_sq = 43'(sqx_reg) + 43'(sqy_reg);
    assign sel     = dist_sq < $signed({7'd0, csq_reg});

    always_comb
    begin
        s2_next.pos_x       = s1_item_reg.pos_x;
        s2_next.pos_y       = s1_item_reg.pos_y;
        s2_next.init_x      = s1_item_reg.init_x;
        s2_next.init_y      = s1_item_reg.init_y;
        s2_next.pinned      = s1_item_reg.pinned;
        s2_next.selected    = sel;
        s2_next.break_links = sel && s1_item_reg.buttons[1];
        if (sel && s1_item_reg.buttons[0])
        begin
            s2_next.prev_x = dragx_reg;
            s2_next.prev_y = dragy_reg;
        end
        else
        begin
            s2_next.prev_x = s1_item_reg.prev_x;
            s2_next.prev_y = s1_item_reg.prev_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                s0_valid_reg <= in_valid;
            end
            if (en1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s0_item_reg <= in_item;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            ddx_reg     <= ddx_next;
            ddy_reg     <= ddy_next;
        end
        if (en1)
        begin
            s1_item_reg <= s0_item_reg;
            sqx_reg     <= dx_reg * dx_reg;
            sqy_reg     <= dy_reg * dy_reg;
            csq_reg     <= cfg.cursor_size * cfg.cursor_size;
            dragx_reg   <= sat_pos(22'(s0_item_reg.pos_x) - 22'(ddx_reg));
            dragy_reg   <= sat_pos(22'(s0_item_reg.pos_y) - 22'(ddy_reg));
        end
        if (en2)
        begin
            s2_item_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

[hw/rtl/vps_back.sv]
module vps_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vps_pkg::mid_item_t  in_item,
    input  vps_pkg::cfg_t       cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output vps_pkg::out_item_t  out_item
);

    import vps_pkg::*;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic               en1, en2, en3, en4, en5;
    mid_item_t          i1_reg, i2_reg, i3_reg, i4_reg;
    logic signed [20:0] vx_reg, vy_reg;
    logic [16:0]        k_reg;
    logic [31:0]        dtsq_reg;
    logic signed [17:0] k_s;
    logic signed [38:0] vkx_reg, vky_reg;
    logic signed [41:0] akx_reg, aky_reg;
    logic [16:0]        dt2_next, dt2_reg;
    logic signed [39:0] vkrx_reg, vkry_reg;
    logic signed [59:0] akdx_reg, akdy_reg;
    logic signed [60:0] totx, toty;
    logic signed [26:0] dlx_reg, dly_reg;
    logic [39:0]        axis_x, axis_y;
    out_item_t          res_next, res_reg;

    // returns {new_pos, new_prev} for one axis after the window clamp
    function automatic logic [39:0] axis_step(
        input logic signed [19:0] pos,
        input logic signed [26:0] delta,
        input logic [11:0]        bound
    );
        logic signed [27:0] n;
        logic signed [27:0] hi;
        logic [39:0]        r;
        n  = 28'(pos) + 28'(delta);
        hi = $signed({10'd0, bound, 6'd0});
        if (n > hi)
        begin
            r = {hi[19:0], hi[19:0]};
        end
        else if (n[27])
        begin
            r = '0;
        end
        else
        begin
            r = {n[19:0], pos};
        end
        return r;
    endfunction

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign k_s      = $signed({1'b0, k_reg});
    assign dt2_next = 17'((33'(dtsq_reg) + 33'd32768) >> 16);
    assign totx     = 61'($signed({vkrx_reg, 18'd0})) + 61'(akdx_reg);
    assign toty     = 61'($signed({vkry_reg, 18'd0})) + 61'(akdy_reg);
    assign axis_x   = axis_step(i4_reg.pos_x, dlx_reg, cfg.window_width);
    assign axis_y   = axis_step(i4_reg.pos_y, dly_reg, cfg.window_height);

    always_comb
    begin
        res_next.selected    = i4_reg.selected;
        res_next.break_links = i4_reg.break_links;
        if (i4_reg.pinned)
        begin
            res_next.new_pos_x  = i4_reg.init_x;
            res_next.new_pos_y  = i4_reg.init_y;
            res_next.new_prev_x = i4_reg.prev_x;
            res_next.new_prev_y = i4_reg.prev_y;
        end
        else
        begin
            res_next.new_pos_x  = axis_x[39:20];
            res_next.new_prev_x = axis_x[19:0];
            res_next.new_pos_y  = axis_y[39:20];
            res_next.new_prev_y = axis_y[19:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            i1_reg   <= in_item;
            vx_reg   <= 21'(in_item.pos_x) - 21'(in_item.prev_x);
            vy_reg   <= 21'(in_item.pos_y) - 21'(in_item.prev_y);
            k_reg    <= 17'h10000 - {1'b0, cfg.drag};
            dtsq_reg <= cfg.delta_time * cfg.delta_time;
        end
        if (en2)
        begin
            i2_reg  <= i1_reg;
            vkx_reg <= vx_reg * k_s;
            vky_reg <= vy_reg * k_s;
            akx_reg <= cfg.accel_x * k_s;
            aky_reg <= cfg.accel_y * k_s;
            dt2_reg <= dt2_next;
        end
        if (en3)
        begin
            i3_reg   <= i2_reg;
            // rounding half added here: 2^33 sits at bit 15 of v*k
            vkrx_reg <= 40'(vkx_reg) + 40'sd32768;
            vkry_reg <= 40'(vky_reg) + 40'sd32768;
            akdx_reg <= akx_reg * $signed({1'b0, dt2_reg});
            akdy_reg <= aky_reg * $signed({1'b0, dt2_reg});
        end
        if (en4)
        begin
            i4_reg  <= i3_reg;
            dlx_reg <= totx[60:34];
            dly_reg <= toty[60:34];
        end
        if (en5)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_item  = res_reg;

endmodule

[hw/rtl/verlet_particle_step_core.sv]
// channel   | handshake                     | payload
// ----------+-------------------------------+-----------------------------
// particle  | push / full                   | particle (in_item_t)
// result    | pop / empty                   | result (out_item_t)
// config    | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One item per cycle sustained unless pop is held; a particle passes through
// three front stages, the middle queue, five back stages and the output queue.
// The back stages are set by the multiply chain accel * k * dt2.
// Reset clears all valid flags and queue counts and loads the register defaults.
// A held pop backs up into the output queue, then the back stages, then the
// middle queue; full rises only when the front stages fill too.
module verlet_particle_step_core #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  vps_pkg::in_item_t                   particle,
    input  logic                                pop,
    output logic                                empty,
    output vps_pkg::out_item_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [vps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import vps_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      front_ready;
    logic      mid_wr_valid, mid_wr_ready, mid_rd_valid, mid_rd_ready;
    mid_item_t mid_wr_item, mid_rd_item;
    logic      back_valid, back_ready;
    out_item_t back_item;
    logic      res_valid;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        unique case (cfg_index)
            REG_DELTA_TIME:    cfg_next.delta_time    = cfg_data[15:0];
            REG_DRAG:          cfg_next.drag          = cfg_data[15:0];
            REG_ACCEL_X:       cfg_next.accel_x       = $signed(cfg_data[23:0]);
            REG_ACCEL_Y:       cfg_next.accel_y       = $signed(cfg_data[23:0]);
            REG_ELASTICITY:    cfg_next.elasticity    = cfg_data[18:0];
            REG_CURSOR_SIZE:   cfg_next.cursor_size   = cfg_data[17:0];
            REG_WINDOW_WIDTH:  cfg_next.window_width  = cfg_data[11:0];
            REG_WINDOW_HEIGHT: cfg_next.window_height = cfg_data[11:0];
            default:           cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delta_time    <= RST_DELTA_TIME;
            cfg_reg.drag          <= RST_DRAG;
            cfg_reg.accel_x       <= RST_ACCEL_X;
            cfg_reg.accel_y       <= RST_ACCEL_Y;
            cfg_reg.elasticity    <= RST_ELASTICITY;
            cfg_reg.cursor_size   <= RST_CURSOR_SIZE;
            cfg_reg.window_width  <= RST_WINDOW_WIDTH;
            cfg_reg.window_height <= RST_WINDOW_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_reg <= cfg_next;
        end
    end

    vps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (front_ready),
        .in_item   (particle),
        .cfg       (cfg_reg),
        .out_valid (mid_wr_valid),
        .out_ready (mid_wr_ready),
        .out_item  (mid_wr_item)
    );

    vps_queue #(
        .DEPTH (MID_DEPTH),
        .T     (mid_item_t)
    ) u_mid_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (mid_wr_valid),
        .wr_ready (mid_wr_ready),
        .wr_item  (mid_wr_item),
        .rd_valid (mid_rd_valid),
        .rd_ready (mid_rd_ready),
        .rd_item  (mid_rd_item)
    );

    vps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_rd_valid),
        .in_ready  (mid_rd_ready),
        .in_item   (mid_rd_item),
        .cfg       (cfg_reg),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    vps_queue #(
        .DEPTH (OUT_DEPTH),
        .T     (out_item_t)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (back_valid),
        .wr_ready (back_ready),
        .wr_item  (back_item),
        .rd_valid (res_valid),
        .rd_ready (pop),
        .rd_item  (result)
    );

    assign full  = !front_ready;
    assign empty = !res_valid;

endmodule

[hw/rtl/vps_checker.sv]
`include "assert_macros.svh"

module vps_checker #(
    parameter int CNT_W = 8
) (
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input logic pop,
    input logic empty
);

    logic [CNT_W-1:0] outstanding_reg, outstanding_next;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (push && !full)
        begin
            outstanding_next = outstanding_next + 1'b1;
        end
        if (pop && !empty)
        begin
            outstanding_next = outstanding_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    `VPS_ASSERT(a_no_phantom_item, (outstanding_reg == '0) |-> empty, "result without item")
    `VPS_ASSERT(a_idle_not_full, (outstanding_reg == '0) |-> !full, "full while idle")
    `VPS_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty, "result dropped")

endmodule

bind verlet_particle_step_core vps_checker u_vps_checker (.*);

[tb/tb_verlet_particle_step_core.sv]
module tb_verlet_particle_step_core;
    import vps_pkg::*;

    localparam longint POS_MIN = -524288;
    localparam longint POS_MAX = 524287;

    class particle_scoreboard;
        logic [15:0] dt_frac;
        logic [15:0] drag_frac;
        longint      acc_x;
        longint      acc_y;
        longint      elast;
        longint      cursor;
        longint      win_w;
        longint      win_h;
        out_item_t   pending_results[$];
        int          errors;

        function new();
            dt_frac   = RST_DELTA_TIME;
            drag_frac = RST_DRAG;
            acc_x     = RST_ACCEL_X;
            acc_y     = RST_ACCEL_Y;
            elast     = RST_ELASTICITY;
            cursor    = RST_CURSOR_SIZE;
            win_w     = RST_WINDOW_WIDTH;
            win_h     = RST_WINDOW_HEIGHT;
            errors    = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [23:0] val);
            case (idx)
                REG_DELTA_TIME:    dt_frac = val[15:0];
                REG_DRAG:          drag_frac = val[15:0];
                REG_ACCEL_X:       acc_x = signed'(val);
                REG_ACCEL_Y:       acc_y = signed'(val);
                REG_ELASTICITY:    elast = val[18:0];
                REG_CURSOR_SIZE:   cursor = val[17:0];
                REG_WINDOW_WIDTH:  win_w = val[11:0];
                REG_WINDOW_HEIGHT: win_h = val[11:0];
                default:           ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // damped Verlet step on one axis, then window clamp
        function void step_axis(input longint pos, input longint prv, input longint acc,
                                input longint bound, input longint k, input longint dt2,
                                output longint np, output longint nq);
            longint total;
            longint n;
            total = (pos - prv) * k * 262144 + acc * k * dt2;
            n = pos + ((total + 64'sd8589934592) >>> 34);
            if (n > bound * 64)
            begin
                np = bound * 64;
                nq = bound * 64;
            end
            else if (n < 0)
            begin
                np = 0;
                nq = 0;
            end
            else
            begin
                np = n;
                nq = pos;
            end
        endfunction

        function out_item_t step_particle(in_item_t it);
            longint    px, py, qx, qy, mx, my, dx, dy, ddx, ddy;
            longint    k, dt2, npx, npy, nqx, nqy, d;
            logic      sel;
            out_item_t r;
            px = it.pos_x;
            py = it.pos_y;
            qx = it.prev_x;
            qy = it.prev_y;
            mx = it.mouse_x;
            my = it.mouse_y;
            dx = px - mx;
            dy = py - my;
            sel = (dx * dx + dy * dy) < cursor * cursor;
            if (it.buttons[0] && sel)
            begin
                ddx = clip(mx - it.mouse_prev_x, -elast, elast);
                ddy = clip(my - it.mouse_prev_y, -elast, elast);
                qx = clip(px - ddx, POS_MIN, POS_MAX);
                qy = clip(py - ddy, POS_MIN, POS_MAX);
            end
            if (it.pinned)
            begin
                npx = it.init_x;
                npy = it.init_y;
                nqx = qx;
                nqy = qy;
            end
            else
            begin
                k = 65536 - longint'(drag_frac);
                d = dt_frac;
                dt2 = (d * d + 32768) >> 16;
                step_axis(px, qx, acc_x, win_w, k, dt2, npx, nqx);
                step_axis(py, qy, acc_y, win_h, k, dt2, npy, nqy);
            end
            r.new_pos_x   = npx[19:0];
            r.new_pos_y   = npy[19:0];
            r.new_prev_x  = nqx[19:0];
            r.new_prev_y  = nqy[19:0];
            r.selected    = sel;
            r.break_links = it.buttons[1] && sel;
            return r;
        endfunction

        function void note_particle(in_item_t it);
            pending_results.push_back(step_particle(it));
        endfunction

        function void cmp(string name, logic signed [63:0] e, logic signed [63:0] g);
            if (e !== g)
            begin
                errors++;
                $error("%s: expected %0d, got %0d", name, e, g);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending_results.size() == 0)
            begin
                errors++;
                $error("result with no particle outstanding");
                return;
            end
            e = pending_results.pop_front();
            cmp("new_pos_x", e.new_pos_x, got.new_pos_x);
            cmp("new_pos_y", e.new_pos_y, got.new_pos_y);
            cmp("new_prev_x", e.new_prev_x, got.new_prev_x);
            cmp("new_prev_y", e.new_prev_y, got.new_prev_y);
            cmp("selected", e.selected, got.selected);
            cmp("break_links", e.break_links, got.break_links);
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    particle = '0;
    logic        pop = 1'b0;
    logic        empty;
    out_item_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    particle_scoreboard sb = new();
    int tx_idle_pct = 32;
    int rx_idle_pct = 32;
    int rx_hold_cycles = 0;

    verlet_particle_step_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .particle  (particle),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 200000);
        $display("** verlet_particle_step_core: FAILED **");
        $finish;
    end

    // result side: random pop, optional long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result(result);
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic longint rand_in(longint lo, longint hi);
        return lo + longint'($urandom_range(int'(hi - lo)));
    endfunction

    function automatic logic signed [19:0] sat20(longint v);
        longint c;
        c = (v < POS_MIN) ? POS_MIN : ((v > POS_MAX) ? POS_MAX : v);
        return c[19:0];
    endfunction

    function automatic in_item_t mk(input longint px, py, qx, qy, ix, iy, input int pin,
                                    input longint mx, my, mpx, mpy, input int btn);
        in_item_t it;
        it.pos_x        = px[19:0];
        it.pos_y        = py[19:0];
        it.prev_x       = qx[19:0];
        it.prev_y       = qy[19:0];
        it.init_x       = ix[19:0];
        it.init_y       = iy[19:0];
        it.pinned       = pin[0];
        it.mouse_x      = mx[19:0];
        it.mouse_y      = my[19:0];
        it.mouse_prev_x = mpx[19:0];
        it.mouse_prev_y = mpy[19:0];
        it.buttons      = btn[1:0];
        return it;
    endfunction

    function automatic in_item_t make_particle();
        logic [255:0] bits;
        in_item_t     it;
        longint       xr, yr, px, py, mx, my, reach, wig;
        if ($urandom_range(99) < 15)
        begin
            for (int i = 0; i < 8; i++)
                bits[i*32 +: 32] = $urandom();
            return in_item_t'(bits[$bits(in_item_t)-1:0]);
        end
        xr = sb.win_w * 64;
        yr = sb.win_h * 64;
        px = rand_in(-256, xr + 256);
        py = rand_in(-256, yr + 256);
        it.pos_x  = sat20(px);
        it.pos_y  = sat20(py);
        it.prev_x = sat20(px + rand_in(-1500, 1500));
        it.prev_y = sat20(py + rand_in(-1500, 1500));
        it.init_x = sat20(rand_in(0, xr));
        it.init_y = sat20(rand_in(0, yr));
        it.pinned = ($urandom_range(9) == 0);
        reach = sb.cursor + 64;
        if ($urandom_range(1) == 1)
        begin
            mx = px + rand_in(-reach, reach);
            my = py + rand_in(-reach, reach);
        end
        else
        begin
            mx = rand_in(-256, xr + 256);
            my = rand_in(-256, yr + 256);
        end
        wig = 2 * sb.elast + 64;
        it.mouse_x      = sat20(mx);
        it.mouse_y      = sat20(my);
        it.mouse_prev_x = sat20(mx + rand_in(-wig, wig));
        it.mouse_prev_y = sat20(my + rand_in(-wig, wig));
        it.buttons      = 2'($urandom_range(3));
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        particle <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_particle(it);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input int setting);
        logic [23:0] vals [8];
        case (setting)
            1:
            begin
                vals[REG_DELTA_TIME]    = 24'd65535;
                vals[REG_DRAG]          = 24'd0;
                vals[REG_ACCEL_X]       = 24'h7FFFFF;
                vals[REG_ACCEL_Y]       = 24'h800000;
                vals[REG_ELASTICITY]    = 24'd524287;
                vals[REG_CURSOR_SIZE]   = 24'd262143;
                vals[REG_WINDOW_WIDTH]  = 24'd4095;
                vals[REG_WINDOW_HEIGHT] = 24'd4095;
            end
            2:
            begin
                vals[REG_DELTA_TIME]    = 24'd0;
                vals[REG_DRAG]          = 24'd65535;
                vals[REG_ACCEL_X]       = 24'h800000;
                vals[REG_ACCEL_Y]       = 24'h7FFFFF;
                vals[REG_ELASTICITY]    = 24'd0;
                vals[REG_CURSOR_SIZE]   = 24'd0;
                vals[REG_WINDOW_WIDTH]  = 24'd0;
                vals[REG_WINDOW_HEIGHT] = 24'd0;
            end
            5:
            begin
                vals[REG_DELTA_TIME]    = 24'($urandom_range(65535));
                vals[REG_DRAG]          = 24'($urandom_range(65535));
                vals[REG_ACCEL_X]       = 24'($urandom());
                vals[REG_ACCEL_Y]       = 24'($urandom());
                vals[REG_ELASTICITY]    = 24'($urandom_range(524287));
                vals[REG_CURSOR_SIZE]   = 24'($urandom_range(262143));
                vals[REG_WINDOW_WIDTH]  = 24'($urandom_range(4095));
                vals[REG_WINDOW_HEIGHT] = 24'($urandom_range(4095));
            end
            7:
            begin
                vals[REG_DELTA_TIME]    = 24'(RST_DELTA_TIME);
                vals[REG_DRAG]          = 24'(RST_DRAG);
                vals[REG_ACCEL_X]       = RST_ACCEL_X;
                vals[REG_ACCEL_Y]       = RST_ACCEL_Y;
                vals[REG_ELASTICITY]    = 24'(RST_ELASTICITY);
                vals[REG_CURSOR_SIZE]   = 24'(RST_CURSOR_SIZE);
                vals[REG_WINDOW_WIDTH]  = 24'(RST_WINDOW_WIDTH);
                vals[REG_WINDOW_HEIGHT] = 24'(RST_WINDOW_HEIGHT);
            end
            default:
            begin
                vals[REG_DELTA_TIME]    = 24'($urandom_range(4000, 500));
                vals[REG_DRAG]          = 24'($urandom_range(3000));
                vals[REG_ACCEL_X]       = 24'(rand_in(-50000, 50000));
                vals[REG_ACCEL_Y]       = 24'(rand_in(-300000, 300000));
                vals[REG_ELASTICITY]    = 24'($urandom_range(5000));
                vals[REG_CURSOR_SIZE]   = 24'($urandom_range(5000));
                vals[REG_WINDOW_WIDTH]  = 24'($urandom_range(1200, 100));
                vals[REG_WINDOW_HEIGHT] = 24'($urandom_range(1000, 100));
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(reg_index_t'(i), vals[i]);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        in_item_t dir_q[$];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: cursor 1280, elasticity 640, window 800 x 600
        dir_q.push_back(mk(25600, 19200, 25600, 19200, 0, 0, 0,
                           -100000, -100000, -100000, -100000, 0));
        dir_q.push_back(mk(25600, 19200, 25000, 19800, 0, 0, 0,
                           -100000, -100000, -100000, -100000, 3));
        dir_q.push_back(mk(25600, 19200, 25500, 19100, 0, 0, 0,
                           25600, 19200, 25600, 19200, 0));
        dir_q.push_back(mk(25600, 19200, 25600, 19200, 0, 0, 0,
                           25700, 19150, 25600, 19200, 1));
        dir_q.push_back(mk(25600, 19200, 25600, 19200, 0, 0, 0,
                           25600, 19200, 20600, 24200, 1));
        dir_q.push_back(mk(25600, 19200, 25600, 19200, 0, 0, 0,
                           25600, 19200, 30600, 14200, 1));
        dir_q.push_back(mk(25600, 19200, 25600, 19200, 0, 0, 0,
                           40000, 30000, 35000, 25000, 1));
        dir_q.push_back(mk(25600, 19200, 25600, 19200, 0, 0, 0,
                           25600, 19300, 25600, 19200, 2));
        dir_q.push_back(mk(25600, 19200, 25600, 19200, 0, 0, 0,
                           25300, 19200, 26000, 19000, 3));
        dir_q.push_back(mk(25600, 19200, 25000, 19000, 1000, 2000, 1,
                           25600, 19200, 24000, 20000, 1));
        dir_q.push_back(mk(25600, 19200, 25000, 19000, 1000, 2000, 1,
                           -100000, -100000, -100000, -100000, 0));
        // overshoot the right and lower edges
        dir_q.push_back(mk(51200, 38400, 50000, 37000, 0, 0, 0,
                           0, 0, 0, 0, 0));
        // undershoot below zero on both axes
        dir_q.push_back(mk(10, 10, 2000, 2000, 0, 0, 0,
                           -100000, -100000, -100000, -100000, 0));
        dir_q.push_back(mk(POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MAX, POS_MAX, 0,
                           POS_MIN, POS_MIN, POS_MAX, POS_MAX, 3));
        dir_q.push_back(mk(POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MIN, POS_MIN, 0,
                           POS_MAX, POS_MAX, POS_MIN, POS_MIN, 3));
        // drag pushes prev past the positive and negative limits
        dir_q.push_back(mk(524200, -524200, 0, 0, 0, 0, 0,
                           524000, -524000, POS_MAX, POS_MIN, 1));
        dir_q.push_back(mk(-524200, 524200, 0, 0, 0, 0, 1,
                           -524000, 524000, POS_MIN, POS_MAX, 3));
        // distance exactly at the cursor radius, then just inside
        dir_q.push_back(mk(25600, 19200, 25600, 19200, 0, 0, 0,
                           24320, 19200, 24000, 19200, 3));
        dir_q.push_back(mk(25600, 19200, 25600, 19200, 0, 0, 0,
                           24321, 19200, 24000, 19200, 3));
        dir_q.push_back(mk(100, 100, 100, 100, POS_MIN, POS_MAX, 1,
                           POS_MAX, POS_MIN, POS_MIN, POS_MAX, 2));
        foreach (dir_q[i])
            send_item(dir_q[i]);

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            program_regs(ph);
            tx_idle_pct = (ph == 3) ? 0 : 32;
            rx_idle_pct = (ph == 3) ? 0 : 32;
            if (ph == 1)
                rx_hold_cycles = 300;
            repeat (48)
                send_item(make_particle());
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("** verlet_particle_step_core: PASSED **");
        else
            $display("** verlet_particle_step_core: FAILED **");
        $finish;
    end
endmodule
